// ----- hdl/smpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted max-priority queue.
package smpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int KEY_W           = 32;

	// input kind codes
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [KEY_W-1:0] key;
	} smpq_cmd_t;

endpackage

// ----- hdl/smpq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a key and shifts with its neighbors.
module smpq_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                      clk,
	input  smpq_pkg::smpq_cmd_t       cmd,
	input  logic [CNT_W-1:0]          count,
	input  logic [smpq_pkg::KEY_W-1:0] left_key,
	input  logic                      left_gt,
	input  logic [smpq_pkg::KEY_W-1:0] right_key,
	output logic [smpq_pkg::KEY_W-1:0] key,
	output logic                      gt
);
	import smpq_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic             occupied;

	assign occupied = CNT_W'(IDX) < count;
	// stored key strictly larger than the new one: this slot stays put
	assign gt  = occupied && ($signed(key_q) > $signed(cmd.key));
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!gt) begin
				key_q <= left_gt ? cmd.key : left_key;
			end
		end else if (cmd.rem) begin
			key_q <= right_key;
		end
	end

endmodule

// ----- hdl/sorted_max_priority_queue_top.sv -----
`timescale 1ns / 1ps
// Sorted max-priority queue: top level with stream ports and the chain of cells.
//
// Input channel (s_*): one word per operation. s_tuser selects the operation
// (insert or remove largest), s_tdata carries the signed key to insert.
// Output channel (m_*): exactly one result word per accepted input word, in
// order. m_tuser carries the status (ok, removal from empty, insert into full);
// m_tdata carries the removed key, the empty flag and the entry count after
// the operation.
// Result: registered, and shown in the cycle after the input word is accepted.
// Throughput: one word per cycle while m_tready is high. Every cell compares its
// key with the broadcast key and shifts toward its neighbor in the same cycle, so
// the whole chain is updated together whatever its depth.
// Reset: the queue is empty and no result is pending; keys are not cleared.
// Stall: the result register holds while m_tready is low, and s_tready drops
// until the pending result is taken; no word is lost or repeated.
module sorted_max_priority_queue_top #(
	parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int OUT_W = ((smpq_pkg::KEY_W + 1 + CNT_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [smpq_pkg::KEY_W-1:0] s_tdata,  // [31:0] key_in
	input  logic                       s_tuser,  // [0] kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_W-1:0]           m_tdata,  // [31:0] key_out, [32] is_empty, entry_count
	output logic [1:0]                 m_tuser   // [1:0] status
);
	import smpq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             m_tvalid_q;
	logic [KEY_W-1:0] key_out_q;
	logic [1:0]       status_q;
	logic             accept;
	logic             full;
	logic             empty;
	smpq_cmd_t        cmd;
	logic [KEY_W-1:0] cell_key [QUEUE_DEPTH];
	logic             cell_gt  [QUEUE_DEPTH];
	logic [1:0]       status_next;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;

	assign cmd.ins = accept && (s_tuser == KIND_INSERT) && !full;
	assign cmd.rem = accept && (s_tuser == KIND_REMOVE) && !empty;
	assign cmd.key = s_tdata;

	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.rem) begin
			count_next = count_q - 1'b1;
		end
		if (s_tuser == KIND_INSERT && full) begin
			status_next = ST_FULL;
		end else if (s_tuser == KIND_REMOVE && empty) begin
			status_next = ST_EMPTY;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic [KEY_W-1:0] left_key;
			logic             left_gt;
			logic [KEY_W-1:0] right_key;
			if (gi == 0) begin : g_head
				assign left_key = cmd.key;
				assign left_gt  = 1'b1;
			end else begin : g_body
				assign left_key = cell_key[gi-1];
				assign left_gt  = cell_gt[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign right_key = cell_key[gi];
			end else begin : g_mid
				assign right_key = cell_key[gi+1];
			end
			smpq_cell #(
				.IDX   (gi),
				.CNT_W (CNT_W)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.count     (count_q),
				.left_key  (left_key),
				.left_gt   (left_gt),
				.right_key (right_key),
				.key       (cell_key[gi]),
				.gt        (cell_gt[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload of the result word; count_q itself serves as the entry count
	always_ff @(posedge clk) begin
		if (accept) begin
			key_out_q <= cmd.rem ? cell_key[0] : '0;
			status_q  <= status_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_W'({count_q, (count_q == '0), key_out_q});

	// count stays within the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	// a successful removal drops the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == KIND_REMOVE && !empty |=> count_q == $past(count_q) - 1'b1)
		else $error("removal did not decrement count");

	// a failed operation never reports a key
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY) |-> m_tdata[KEY_W-1:0] == '0)
		else $error("key reported on failed operation");

	// head of the chain is at least as large as the next key
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> $signed(cell_key[0]) >= $signed(cell_key[1]))
		else $error("chain out of order");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the sorted max-priority queue.
module tb;
	import smpq_pkg::*;

	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int OUT_W      = ((KEY_W + 1 + CNT_W + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 200000;
	localparam int N_DIRECTED = 19;
	localparam int N_RANDOM   = 540;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [1:0]       status;
		logic             empty;
		logic [CNT_W-1:0] count;
	} pq_result_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic             typed;
		logic [KEY_W-1:0] exp_key;
		logic [1:0]       exp_status;
		logic             exp_empty;
		logic [CNT_W-1:0] exp_count;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [KEY_W-1:0] s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;

	logic signed [KEY_W-1:0] shadow_keys[$];
	pq_result_t              awaited_results[$];
	stim_row_t               stim_rows [N_DIRECTED];

	int tx_idle_pct;
	int rx_stall_pct;
	int mismatch_count;
	int results_seen;
	int n_inserts;
	int n_removes;
	int n_full_rejects;
	int n_empty_removes;
	int cycle_count;

	sorted_max_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Apply one operation to the shadow queue and return the result it yields.
	function automatic pq_result_t queue_op_result(input logic kind, input logic [KEY_W-1:0] key);
		pq_result_t res;
		int         pos;
		res = '0;
		res.status = ST_OK;
		if (kind == KIND_INSERT) begin
			if (shadow_keys.size() >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = shadow_keys.size();
				for (int i = 0; i < shadow_keys.size(); i++) begin
					if (shadow_keys[i] <= $signed(key)) begin
						pos = i;
						break;
					end
				end
				shadow_keys.insert(pos, $signed(key));
			end
		end else begin
			if (shadow_keys.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.key = shadow_keys.pop_front();
			end
		end
		res.empty = (shadow_keys.size() == 0);
		res.count = CNT_W'(shadow_keys.size());
		return res;
	endfunction

	// Present one word and hold it until accepted, then log its expected result.
	task automatic send_word(input logic kind, input logic [KEY_W-1:0] key, input logic typed,
	                         input pq_result_t typed_res);
		pq_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		res = queue_op_result(kind, key);
		if (typed) begin
			res = typed_res;
		end
		awaited_results.push_back(res);
		if (kind == KIND_INSERT) begin
			n_inserts++;
		end else begin
			n_removes++;
		end
		if (res.status == ST_FULL) begin
			n_full_rejects++;
		end
		if (res.status == ST_EMPTY) begin
			n_empty_removes++;
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(4))
			0: k = KEY_W'($signed($urandom_range(8)) - 4);
			1: begin
				case ($urandom_range(3))
					0: k = 32'h7FFF_FFFF;
					1: k = 32'h8000_0000;
					2: k = 32'h0000_0000;
					default: k = 32'hFFFF_FFFF;
				endcase
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// Check each result word against the oldest expectation.
	always @(posedge clk) begin
		pq_result_t exp_res;
		pq_result_t got;
		if (m_tvalid && m_tready) begin
			results_seen++;
			got.key    = m_tdata[KEY_W-1:0];
			got.empty  = m_tdata[KEY_W];
			got.count  = m_tdata[KEY_W+1 +: CNT_W];
			got.status = m_tuser;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result word with nothing expected: key %h status %0d",
					         got.key, got.status);
			end else begin
				exp_res = awaited_results.pop_front();
				if (got !== exp_res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch at word %0d: exp key %h st %0d empty %0d cnt %0d, got key %h st %0d empty %0d cnt %0d",
						         results_seen, exp_res.key, exp_res.status, exp_res.empty,
						         exp_res.count, got.key, got.status, got.empty, got.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || rx_stall_pct == 0) begin
			m_tready <= arst_n;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results still awaited",
			         cycle_count, awaited_results.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int  burst_left;
		int  insert_pct;
		int  waited;
		logic kind;

		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = KIND_INSERT;
		m_tready        = 1'b0;
		tx_idle_pct     = 0;
		rx_stall_pct    = 0;
		mismatch_count  = 0;
		results_seen    = 0;
		n_inserts       = 0;
		n_removes       = 0;
		n_full_rejects  = 0;
		n_empty_removes = 0;
		cycle_count     = 0;
		burst_left      = 0;
		insert_pct      = 50;

		// kind, key, typed, expected key, status, empty, count
		stim_rows = '{
			'{KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY, 1'b1, 5'd0},
			'{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    1'b0, 5'd1},
			'{KIND_INSERT, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    1'b0, 5'd2},
			'{KIND_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    1'b0, 5'd3},
			'{KIND_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    1'b0, 5'd4},
			'{KIND_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    1'b0, 5'd5},
			'{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h5555_5555, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h0000_0001, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'hFFFF_FFFE, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h8000_0001, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h7FFF_FFFE, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h1234_5678, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'hC3C3_0F0F, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h0000_0064, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h0000_0001, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK, 1'b0, 5'd0},
			'{KIND_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_FULL,  1'b0, 5'd16},
			'{KIND_REMOVE, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK,    1'b0, 5'd15}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			send_word(stim_rows[r].kind, stim_rows[r].key, stim_rows[r].typed,
			          {stim_rows[r].exp_key, stim_rows[r].exp_status,
			           stim_rows[r].exp_empty, stim_rows[r].exp_count});
		end

		// Bursts lean toward insert or removal, or are balanced, so the queue swings between full and empty.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
				default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
			endcase
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(40, 8);
					case ($urandom_range(2))
						0: insert_pct = 85;
						1: insert_pct = 50;
						default: insert_pct = 15;
					endcase
				end
				burst_left--;
				kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
				send_word(kind, pick_key(), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (awaited_results.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);
		if (awaited_results.size() != 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", awaited_results.size());
		end

		$display("sent %0d words: %0d inserts, %0d removals; checked %0d results",
		         n_inserts + n_removes, n_inserts, n_removes, results_seen);
		$display("rejected inserts on full: %0d, removals on empty: %0d, mismatches: %0d",
		         n_full_rejects, n_empty_removes, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
